// ----- rtl/lfp_pkg.sv -----
`default_nettype none
package lfp_pkg;

  localparam int MapDepth = 360;
  localparam int AngleW   = 9;
  localparam int DistW    = 14;
  localparam int RawW     = 16;
  localparam int AccW     = 26;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  localparam logic [7:0] StartByte = 8'hFA;
  localparam logic [7:0] IndexLow  = 8'hA0;
  localparam logic [7:0] IndexHigh = 8'hF9;
  localparam logic [4:0] LastPos   = 5'd21;
  localparam logic [4:0] FirstPos  = 5'd2;

  // x / 10 == (x * Recip10) >> RecipShift for every 14-bit x.
  localparam logic [15:0] Recip10    = 16'hCCCD;
  localparam int          RecipShift = 19;
  localparam int          ProdW      = DistW + 16;

  localparam logic [DistW-1:0] InvalidFillReset      = 14'd7000;
  localparam logic [DistW-1:0] QuestionableFillReset = 14'd8000;

  localparam logic CfgInvalidFill      = 1'b0;
  localparam logic CfgQuestionableFill = 1'b1;

  typedef enum logic [1:0] {
    KIND_UPDATE   = 2'd0,
    KIND_READ     = 2'd1,
    KIND_CSUM_ERR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_WAIT_INDEX,
    ST_COLLECT,
    ST_EMIT
  } hunt_state_t;

  // One entry per result: raw holds the reading's high byte (flags) and low byte.
  typedef struct packed {
    kind_t             kind;
    logic [AngleW-1:0] angle;
    logic [RawW-1:0]   raw;
    logic              last;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/lidar_frame_parser_to_angle_map_unit.sv -----
`default_nettype none
// Channel    Dir  Signals                  Contents (lowest bit first)
// s_*        in   tvalid tready tdata tuser  tdata: rx_byte[7:0], read_angle[16:8]; tuser: req_type
// m_*        out  tvalid tready tdata tuser  tdata: angle[8:0], distance[22:9]; tuser: kind; tlast
// cfg_*      in   we index data              index 0 invalid_fill, 1 questionable_fill
//
// A byte that completes no frame or a read request is taken every cycle while the queue has
// room; a read result passes the queue, stage 1 and the output register. A frame's last byte
// holds the input while its results (four updates, or one on a checksum error) enter the
// queue one per cycle as room allows. After reset the 360-entry map is cleared one entry per
// cycle, taking no request. Either side may stall; a four-entry queue sits between front and back.
module lidar_frame_parser_to_angle_map_unit
  import lfp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [23:0]      s_tdata,   // rx_byte, read_angle, zero fill
  input  wire logic             s_tuser,   // req_type
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [23:0]           m_tdata,   // angle, distance, zero fill
  output logic [1:0]            m_tuser,   // kind
  output logic                  m_tlast,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [DistW-1:0] cfg_data
);

  logic [DistW-1:0] invalid_fill;
  logic [DistW-1:0] questionable_fill;

  logic clearing;
  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      invalid_fill      <= InvalidFillReset;
      questionable_fill <= QuestionableFillReset;
    end else if (cfg_we) begin
      if (cfg_index == CfgInvalidFill) begin
        invalid_fill <= cfg_data;
      end else if (cfg_index == CfgQuestionableFill) begin
        questionable_fill <= cfg_data;
      end
    end
  end

  lfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .clearing (clearing),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  lfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  lfp_back u_back (
    .clk               (clk),
    .rst               (rst),
    .invalid_fill      (invalid_fill),
    .questionable_fill (questionable_fill),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop),
    .clearing          (clearing),
    .m_tvalid          (m_tvalid),
    .m_tready          (m_tready),
    .m_tdata           (m_tdata),
    .m_tuser           (m_tuser),
    .m_tlast           (m_tlast)
  );

endmodule
`default_nettype wire

// ----- rtl/lfp_front.sv -----
`default_nettype none
module lfp_front
  import lfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic        s_tuser,
  input  wire logic [23:0] s_tdata,
  input  wire logic        clearing,
  input  wire logic        q_full,
  output logic             push,
  output cmd_t             push_cmd
);

  hunt_state_t state, state_next;

  logic [4:0]       pos;
  logic [AccW-1:0]  acc;
  logic [7:0]       lo_save;
  logic [6:0]       base_idx;
  logic [RawW-1:0]  rd_raw [4];
  logic             good;
  logic [1:0]       emit_cnt;

  logic [7:0]        rx_byte;
  logic [AngleW-1:0] read_angle;
  logic              in_fire;
  logic              byte_fire;
  logic [15:0]       fold_sum;
  logic              frame_ok;
  logic [2:0]        rd_slot;
  logic              emit_done;

  assign rx_byte    = s_tdata[7:0];
  assign read_angle = s_tdata[16:8];
  assign in_fire    = s_tvalid && s_tready;
  assign byte_fire  = in_fire && !s_tuser;
  assign rd_slot    = pos[4:2] - 3'd1;

  // Fold the running sum into 15 bits and compare with the transmitted word.
  assign fold_sum = {1'b0, acc[14:0]} + {5'b0, acc[AccW-1:15]};
  assign frame_ok = ({1'b0, fold_sum[14:0]} == {rx_byte, lo_save});

  assign emit_done = !q_full && (!good || emit_cnt == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = (state != ST_EMIT) && !q_full && !clearing;
    push       = 1'b0;
    push_cmd   = '{kind: KIND_READ, angle: read_angle, raw: '0, last: 1'b1};
    if (in_fire && s_tuser) begin
      push = 1'b1;
    end
    case (state)
      ST_HUNT: begin
        if (byte_fire && rx_byte == StartByte) begin
          state_next = ST_WAIT_INDEX;
        end
      end
      ST_WAIT_INDEX: begin
        if (byte_fire) begin
          if (rx_byte >= IndexLow && rx_byte <= IndexHigh) begin
            state_next = ST_COLLECT;
          end else if (rx_byte != StartByte) begin
            state_next = ST_HUNT;
          end
        end
      end
      ST_COLLECT: begin
        if (byte_fire && pos == LastPos) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        push = !q_full;
        if (good) begin
          push_cmd = '{kind: KIND_UPDATE, angle: {base_idx, emit_cnt},
                       raw: rd_raw[emit_cnt], last: (emit_cnt == 2'd3)};
        end else begin
          push_cmd = '{kind: KIND_CSUM_ERR, angle: '0, raw: '0, last: 1'b1};
        end
        if (emit_done) begin
          state_next = ST_HUNT;
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      emit_cnt <= '0;
    end else begin
      if (state == ST_WAIT_INDEX && byte_fire) begin
        pos <= FirstPos;
      end else if (state == ST_COLLECT && byte_fire) begin
        pos <= (pos == LastPos) ? 5'd0 : pos + 5'd1;
      end
      if (state == ST_EMIT && !q_full) begin
        emit_cnt <= emit_done ? 2'd0 : emit_cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WAIT_INDEX && byte_fire) begin
      base_idx <= 7'(rx_byte - IndexLow);
      acc      <= AccW'({rx_byte, StartByte});
    end
    if (state == ST_COLLECT && byte_fire) begin
      if (!pos[0]) begin
        lo_save <= rx_byte;
      end else if (pos < 5'd20) begin
        acc <= (acc << 1) + AccW'({rx_byte, lo_save});
      end
      // Bytes 4..19 hold four readings of four bytes; only the first two count.
      if (pos >= 5'd4 && pos < 5'd20) begin
        if (pos[1:0] == 2'd0) begin
          rd_raw[rd_slot[1:0]][7:0] <= rx_byte;
        end else if (pos[1:0] == 2'd1) begin
          rd_raw[rd_slot[1:0]][15:8] <= rx_byte;
        end
      end
      if (pos == LastPos) begin
        good <= frame_ok;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("front pushed into a full queue");

  assert property (@(posedge clk) disable iff (rst)
    (byte_fire && state == ST_COLLECT && pos == LastPos) |=> (state == ST_EMIT && emit_cnt == 2'd0))
    else $error("frame end did not start result emission");

endmodule
`default_nettype wire

// ----- rtl/lfp_queue.sv -----
`default_nettype none
module lfp_queue
  import lfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      q_valid,
  output cmd_t      q_cmd
);

  cmd_t             entries [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign full    = (count == QCntW'(QDepth));
  assign q_valid = (count != '0);
  assign q_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lfp_back.sv -----
`default_nettype none
module lfp_back
  import lfp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [DistW-1:0] invalid_fill,
  input  wire logic [DistW-1:0] questionable_fill,
  input  wire logic             q_valid,
  input  wire cmd_t             q_cmd,
  output logic                  q_pop,
  output logic                  clearing,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [23:0]           m_tdata,
  output logic [1:0]            m_tuser,
  output logic                  m_tlast
);

  logic [DistW-1:0] dist_map [MapDepth];
  logic [AngleW-1:0] clr_cnt;

  logic             adv;
  logic             valid1;
  cmd_t             cmd1;
  logic [ProdW-1:0] prod1;
  logic [DistW-1:0] dist_w;
  logic             mem_we;

  logic              out_valid;
  kind_t             out_kind;
  logic [AngleW-1:0] out_angle;
  logic              out_last;
  logic [DistW-1:0]  out_dist;
  logic [DistW-1:0]  rd_q;
  logic              out_rd_zero;
  logic [DistW-1:0]  out_distance;

  assign adv   = !out_valid || m_tready;
  assign q_pop = adv && q_valid && !clearing;

  // Map is zeroed one entry per cycle after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == AngleW'(MapDepth - 1)) begin
        clearing <= 1'b0;
      end
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (adv) begin
      valid1 <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd1  <= q_cmd;
      prod1 <= ProdW'(q_cmd.raw[DistW-1:0]) * ProdW'(Recip10);
    end
  end

  always_comb begin
    if (cmd1.raw[15]) begin
      dist_w = invalid_fill;
    end else if (cmd1.raw[14]) begin
      dist_w = questionable_fill;
    end else begin
      dist_w = DistW'(prod1[ProdW-1:RecipShift]);
    end
  end

  assign mem_we = adv && valid1 && cmd1.kind == KIND_UPDATE
                  && cmd1.angle < AngleW'(MapDepth);

  always_ff @(posedge clk) begin
    if (clearing) begin
      dist_map[clr_cnt] <= '0;
    end else if (mem_we) begin
      dist_map[cmd1.angle] <= dist_w;
    end
    if (adv && valid1) begin
      rd_q <= dist_map[cmd1.angle];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && valid1) begin
      out_kind    <= cmd1.kind;
      out_angle   <= cmd1.angle;
      out_last    <= cmd1.last;
      out_dist    <= (cmd1.kind == KIND_UPDATE) ? dist_w : '0;
      out_rd_zero <= (cmd1.angle >= AngleW'(MapDepth));
    end
  end

  always_comb begin
    if (out_kind == KIND_READ) begin
      out_distance = out_rd_zero ? '0 : rd_q;
    end else begin
      out_distance = out_dist;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {1'b0, out_distance, out_angle};

  assert property (@(posedge clk) disable iff (rst) clearing |-> !q_pop)
    else $error("command taken while the map is being cleared");

  assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_cnt) == AngleW'(MapDepth - 1))
    else $error("map clear ended before the last entry");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |=> out_valid)
    else $error("stalled result dropped");

endmodule
`default_nettype wire

// ----- verif/tb_lidar_frame_parser_to_angle_map_unit.sv -----
`timescale 1ns / 1ps
module tb_lidar_frame_parser_to_angle_map_unit;
  import lfp_pkg::*;

  localparam int LimitCycles = 400000;
  localparam int FrameLen    = 22;
  localparam int SettleCycles = 8;
  localparam int DrainCycles = 20;
  localparam int HoldCycles  = 300;

  typedef enum logic [1:0] {
    CS_GOOD,
    CS_BAD,
    CS_SIGN
  } csum_mode_t;

  typedef enum logic [1:0] {
    ROW_READ,
    ROW_BYTE,
    ROW_FRAME
  } row_op_t;

  typedef struct packed {
    kind_t             kind;
    logic [AngleW-1:0] angle;
    logic [DistW-1:0]  distance;
    logic              last;
  } map_result_t;

  typedef struct packed {
    row_op_t     op;
    logic [8:0]  val;
    logic [63:0] readings;
    csum_mode_t  cs;
    logic        lit;
    map_result_t want;
  } stim_row_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [23:0]      s_tdata;
  logic             s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [23:0]      m_tdata;
  logic [1:0]       m_tuser;
  logic             m_tlast;
  logic             cfg_we;
  logic             cfg_index;
  logic [DistW-1:0] cfg_data;

  // Shadow of the decoder: scan state, frame buffer, distance map and fills.
  hunt_state_t              scan_state;
  int                       frame_pos;
  logic [8*FrameLen-1:0]    frame_buf;
  logic [DistW-1:0]         dist_map [MapDepth];
  logic [DistW-1:0]         fill_invalid;
  logic [DistW-1:0]         fill_questionable;

  map_result_t expected_q[$];
  map_result_t no_want;
  int          errors = 0;
  int          cycles = 0;
  int          items_sent = 0;
  bit          hold_req = 0;
  bit          no_gaps = 0;

  lidar_frame_parser_to_angle_map_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      flag_error($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [14:0] frame_checksum(input logic [159:0] words);
    logic [31:0] acc;
    acc = '0;
    for (int i = 0; i < 10; i++)
      acc = (acc << 1) + words[16*i +: 16];
    return acc[14:0] + acc[31:15];
  endfunction

  function automatic logic [DistW-1:0] reading_dist(input logic [15:0] rd);
    if (rd[15]) return fill_invalid;
    if (rd[14]) return fill_questionable;
    return rd[13:0] / 10;
  endfunction

  task automatic expect_result(input kind_t k, input logic [AngleW-1:0] a,
                               input logic [DistW-1:0] d, input logic l);
    map_result_t r;
    r.kind     = k;
    r.angle    = a;
    r.distance = d;
    r.last     = l;
    expected_q.push_back(r);
  endtask

  task automatic predict_request(input logic req, input logic [7:0] b,
                                 input logic [AngleW-1:0] ra);
    logic [AngleW-1:0] ang;
    logic [DistW-1:0]  d;
    if (req) begin
      if (ra < MapDepth) d = dist_map[ra];
      else d = '0;
      expect_result(KIND_READ, ra, d, 1'b1);
      return;
    end
    case (scan_state)
      ST_HUNT: begin
        if (b == StartByte) begin
          frame_buf[7:0] = b;
          scan_state = ST_WAIT_INDEX;
        end
      end
      ST_WAIT_INDEX: begin
        if (b >= IndexLow && b <= IndexHigh) begin
          frame_buf[15:8] = b;
          frame_pos = 2;
          scan_state = ST_COLLECT;
        end else if (b != StartByte) begin
          scan_state = ST_HUNT;
        end
      end
      default: begin
        frame_buf[8*frame_pos +: 8] = b;
        frame_pos++;
        if (frame_pos == FrameLen) begin
          scan_state = ST_HUNT;
          frame_pos = 0;
          // A checksum word with bit 15 set can never equal the folded sum.
          if ({1'b0, frame_checksum(frame_buf[159:0])} != frame_buf[175:160]) begin
            expect_result(KIND_CSUM_ERR, '0, '0, 1'b1);
          end else begin
            for (int k = 0; k < 4; k++) begin
              ang = (frame_buf[15:8] - 160) * 4 + k;
              d = reading_dist(frame_buf[32+32*k +: 16]);
              dist_map[ang] = d;
              expect_result(KIND_UPDATE, ang, d, k == 3);
            end
          end
        end
      end
    endcase
  endtask

  // Offers one request and waits for it to be taken; a literal expectation,
  // when given, replaces what the shadow model predicts for that request.
  task automatic send_request(input logic req, input logic [7:0] b,
                              input logic [AngleW-1:0] ra, input logic lit,
                              input map_result_t lit_want);
    int gap;
    int n0;
    gap = no_gaps ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {7'd0, ra, b};
    do @(posedge clk); while (!s_tready);
    n0 = expected_q.size();
    predict_request(req, b, ra);
    if (lit) begin
      while (expected_q.size() > n0) void'(expected_q.pop_back());
      expected_q.push_back(lit_want);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_request(1'b0, b, 9'($urandom_range(0, 511)), 1'b0, no_want);
    items_sent++;
  endtask

  task automatic send_read(input logic [AngleW-1:0] ra);
    send_request(1'b1, 8'($urandom), ra, 1'b0, no_want);
    items_sent++;
  endtask

  function automatic logic [AngleW-1:0] pick_angle();
    if ($urandom_range(0, 3) != 0) return 9'($urandom_range(0, 359));
    return 9'($urandom_range(0, 511));
  endfunction

  function automatic logic [15:0] rand_reading();
    logic [15:0] v;
    int r;
    v = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 50) v[15:14] = 2'b00;
    else if (r < 60) v = 16'h3FFF;
    else if (r < 65) v = 16'h0000;
    return v;
  endfunction

  function automatic logic [63:0] rand_readings();
    return {rand_reading(), rand_reading(), rand_reading(), rand_reading()};
  endfunction

  task automatic send_frame(input logic [7:0] index, input logic [63:0] readings,
                            input csum_mode_t cs, input int read_pct,
                            input logic lit, input map_result_t lit_want);
    logic [8*FrameLen-1:0] f;
    logic [14:0]           sum;
    f = '0;
    f[7:0]   = StartByte;
    f[15:8]  = index;
    f[31:16] = 16'($urandom);
    for (int k = 0; k < 4; k++) begin
      f[32+32*k +: 16] = readings[16*k +: 16];
      f[48+32*k +: 16] = 16'($urandom);
    end
    sum = frame_checksum(f[159:0]);
    case (cs)
      CS_GOOD: f[175:160] = {1'b0, sum};
      CS_BAD:  f[175:160] = {1'b0, sum ^ 15'($urandom_range(1, 32767))};
      default: f[175:160] = {1'b1, sum};
    endcase
    for (int i = 0; i < FrameLen; i++) begin
      if (i > 0 && $urandom_range(0, 99) < read_pct) send_read(pick_angle());
      send_request(1'b0, f[8*i +: 8], 9'($urandom_range(0, 511)),
                   lit && i == FrameLen - 1, lit_want);
      items_sent++;
    end
  endtask

  task automatic run_random(input int target);
    int r;
    while (items_sent < target) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_frame(8'($urandom_range(160, 249)), rand_readings(), CS_GOOD,
                   $urandom_range(0, 1) ? 8 : 0, 1'b0, no_want);
      end else if (r < 65) begin
        send_frame(8'($urandom_range(160, 249)), rand_readings(), CS_BAD, 4,
                   1'b0, no_want);
      end else if (r < 70) begin
        send_frame(8'($urandom_range(160, 249)), rand_readings(), CS_SIGN, 4,
                   1'b0, no_want);
      end else if (r < 78) begin
        repeat ($urandom_range(1, 5))
          send_byte($urandom_range(0, 4) == 0 ? StartByte : 8'($urandom));
      end else if (r < 88) begin
        repeat ($urandom_range(1, 4)) send_read(pick_angle());
      end else if (r < 94) begin
        // Truncated frame: whatever bytes follow finish it instead.
        send_byte(StartByte);
        send_byte(8'($urandom_range(160, 249)));
        repeat ($urandom_range(0, 10)) begin
          send_byte(8'($urandom));
        end
      end else begin
        send_byte(StartByte);
        case ($urandom_range(0, 3))
          0: send_byte(8'h9F);
          1: send_byte(8'hFB);
          2: send_byte(StartByte);
          default: send_byte(8'($urandom));
        endcase
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_fills(input logic [DistW-1:0] inv, input logic [DistW-1:0] q);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CfgInvalidFill;
    cfg_data  <= inv;
    @(negedge clk);
    cfg_index <= CfgQuestionableFill;
    cfg_data  <= q;
    @(negedge clk);
    cfg_we <= 1'b0;
    fill_invalid = inv;
    fill_questionable = q;
  endtask

  function automatic stim_row_t mk_row(input row_op_t op, input logic [8:0] val,
                                       input logic [63:0] readings, input csum_mode_t cs,
                                       input logic lit, input kind_t k,
                                       input logic [AngleW-1:0] a,
                                       input logic [DistW-1:0] d);
    stim_row_t r;
    r.op            = op;
    r.val           = val;
    r.readings      = readings;
    r.cs            = cs;
    r.lit           = lit;
    r.want.kind     = k;
    r.want.angle    = a;
    r.want.distance = d;
    r.want.last     = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin : check_results
    map_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        flag_error($sformatf("result with nothing expected: kind %0d angle %0d",
                             m_tuser, m_tdata[8:0]));
      end else begin
        want = expected_q.pop_front();
        check_field("kind", m_tuser, want.kind);
        check_field("angle", m_tdata[8:0], want.angle);
        check_field("distance", m_tdata[22:9], want.distance);
        check_field("last", m_tlast, want.last);
      end
    end
  end

  // Output side: short random stalls, ready bursts and one long hold-off.
  initial begin : receiver
    int stall_left;
    int burst_left;
    int n;
    m_tready = 1'b0;
    stall_left = 0;
    burst_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (burst_left > 0) begin
        m_tready <= 1'b1;
        burst_left--;
      end else begin
        n = idle_len();
        if ($urandom_range(0, 24) == 0) begin
          burst_left = 40;
          m_tready <= 1'b1;
        end else if (n == 0) begin
          m_tready <= 1'b1;
        end else begin
          stall_left = n - 1;
          m_tready <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t rows[$];
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CfgInvalidFill;
    cfg_data  = '0;
    no_want   = '0;
    rst       = 1'b1;
    scan_state = ST_HUNT;
    frame_pos = 0;
    frame_buf = '0;
    fill_invalid = InvalidFillReset;
    fill_questionable = QuestionableFillReset;
    for (int i = 0; i < MapDepth; i++) dist_map[i] = '0;

    rows.push_back(mk_row(ROW_READ, 9'd0, '0, CS_GOOD, 1'b1, KIND_READ, 9'd0, '0));
    rows.push_back(mk_row(ROW_READ, 9'd359, '0, CS_GOOD, 1'b1, KIND_READ, 9'd359, '0));
    rows.push_back(mk_row(ROW_READ, 9'd511, '0, CS_GOOD, 1'b1, KIND_READ, 9'd511, '0));
    rows.push_back(mk_row(ROW_BYTE, 9'h00, '0, CS_GOOD, 1'b0, KIND_UPDATE, '0, '0));
    rows.push_back(mk_row(ROW_BYTE, 9'hFF, '0, CS_GOOD, 1'b0, KIND_UPDATE, '0, '0));
    // A repeated start byte keeps waiting for the index; a non-index byte goes back to hunting.
    rows.push_back(mk_row(ROW_BYTE, 9'hFA, '0, CS_GOOD, 1'b0, KIND_UPDATE, '0, '0));
    rows.push_back(mk_row(ROW_BYTE, 9'hFA, '0, CS_GOOD, 1'b0, KIND_UPDATE, '0, '0));
    rows.push_back(mk_row(ROW_BYTE, 9'h9F, '0, CS_GOOD, 1'b0, KIND_UPDATE, '0, '0));
    rows.push_back(mk_row(ROW_BYTE, 9'hFA, '0, CS_GOOD, 1'b0, KIND_UPDATE, '0, '0));
    rows.push_back(mk_row(ROW_BYTE, 9'hFB, '0, CS_GOOD, 1'b0, KIND_UPDATE, '0, '0));
    rows.push_back(mk_row(ROW_BYTE, 9'hFA, '0, CS_GOOD, 1'b0, KIND_UPDATE, '0, '0));
    rows.push_back(mk_row(ROW_FRAME, 9'hA0, 64'h4456_8123_3FFF_0000, CS_GOOD, 1'b0,
                          KIND_UPDATE, '0, '0));
    rows.push_back(mk_row(ROW_READ, 9'd1, '0, CS_GOOD, 1'b0, KIND_READ, '0, '0));
    rows.push_back(mk_row(ROW_FRAME, 9'hF9, 64'h000A_0009_7FFF_C000, CS_GOOD, 1'b0,
                          KIND_UPDATE, '0, '0));
    rows.push_back(mk_row(ROW_READ, 9'd359, '0, CS_GOOD, 1'b0, KIND_READ, '0, '0));
    rows.push_back(mk_row(ROW_FRAME, 9'hC5, rand_readings(), CS_BAD, 1'b1,
                          KIND_CSUM_ERR, '0, '0));
    rows.push_back(mk_row(ROW_FRAME, 9'hA1, rand_readings(), CS_SIGN, 1'b1,
                          KIND_CSUM_ERR, '0, '0));
    rows.push_back(mk_row(ROW_READ, 9'd4, '0, CS_GOOD, 1'b1, KIND_READ, 9'd4, '0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      case (rows[i].op)
        ROW_READ:
          send_request(1'b1, 8'($urandom), rows[i].val, rows[i].lit, rows[i].want);
        ROW_BYTE:
          send_byte(rows[i].val[7:0]);
        default:
          send_frame(rows[i].val[7:0], rows[i].readings, rows[i].cs, 0,
                     rows[i].lit, rows[i].want);
      endcase
    end

    wait_idle();
    write_fills('0, 14'h3FFF);
    hold_req = 1;
    run_random(items_sent + 50);
    wait_idle();
    write_fills(14'h3FFF, '0);
    run_random(items_sent + 50);
    wait_idle();
    write_fills(14'($urandom), 14'($urandom));
    run_random(items_sent + 50);
    wait_idle();
    write_fills(14'($urandom), 14'($urandom));
    run_random(items_sent + 50);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
